// ===== src/pulse_width_remote_code_decoder_assert.svh =====
// assertion macros shared by the decoder checks
`ifndef PULSE_WIDTH_REMOTE_CODE_DECODER_ASSERT_SVH
`define PULSE_WIDTH_REMOTE_CODE_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define PWRCD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, quiet during rst
`define PWRCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/pwrcd_pkg.sv =====
// types, register indexes and constants of the pulse width remote code decoder
package pwrcd_pkg;

  // field widths
  localparam int DUR_W  = 15;
  localparam int CODE_W = 24;
  localparam int IDX_W  = 3;

  // default sizes
  localparam int CAPTURE_DEPTH_DEF = 128;
  localparam int CODE_BITS_DEF     = 24;

  // capture phases
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [1:0] PH_FAIL = 2'd3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_RX_ENABLE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_EXPECTED_CODE = 3'd1;
  localparam logic [IDX_W-1:0] REG_SHORT_MIN     = 3'd2;
  localparam logic [IDX_W-1:0] REG_SHORT_MAX     = 3'd3;
  localparam logic [IDX_W-1:0] REG_LONG_MIN      = 3'd4;
  localparam logic [IDX_W-1:0] REG_LONG_MAX      = 3'd5;
  localparam logic [IDX_W-1:0] REG_SYNC_MIN      = 3'd6;
  localparam logic [IDX_W-1:0] REG_SYNC_MAX      = 3'd7;

  // register reset values
  localparam logic [DUR_W-1:0] SHORT_MIN_RST = 15'd245;
  localparam logic [DUR_W-1:0] SHORT_MAX_RST = 15'd455;
  localparam logic [DUR_W-1:0] LONG_MIN_RST  = 15'd735;
  localparam logic [DUR_W-1:0] LONG_MAX_RST  = 15'd1365;
  localparam logic [DUR_W-1:0] SYNC_MIN_RST  = 15'd7595;
  localparam logic [DUR_W-1:0] SYNC_MAX_RST  = 15'd14105;

  // one captured pulse
  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic             level;
    logic             last;
  } pwrcd_in_t;

  // one capture result
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              decoded;
    logic              trigger;
  } pwrcd_out_t;

  // tolerance window bounds
  typedef struct packed {
    logic [DUR_W-1:0] short_min;
    logic [DUR_W-1:0] short_max;
    logic [DUR_W-1:0] long_min;
    logic [DUR_W-1:0] long_max;
    logic [DUR_W-1:0] sync_min;
    logic [DUR_W-1:0] sync_max;
  } pwrcd_bounds_t;

  // window hits for one duration
  typedef struct packed {
    logic is_short;
    logic is_long;
    logic is_sync;
  } pwrcd_class_t;

endpackage

// ===== src/pwrcd_window.sv =====
// classifies one pulse duration against the short, long and sync windows
module pwrcd_window (
  input  logic [pwrcd_pkg::DUR_W-1:0] duration,
  input  pwrcd_pkg::pwrcd_bounds_t    bounds,
  output pwrcd_pkg::pwrcd_class_t     cls
);

  // inclusive compares, a crossed window never hits
  assign cls.is_short = (duration >= bounds.short_min) && (duration <= bounds.short_max);
  assign cls.is_long  = (duration >= bounds.long_min)  && (duration <= bounds.long_max);
  assign cls.is_sync  = (duration >= bounds.sync_min)  && (duration <= bounds.sync_max);

endmodule

// ===== src/pulse_width_remote_code_decoder.sv =====
// top level: pulse width remote code decoder, sync hunt and pair decode
//
//   port group   dir   handshake              word
//   in_*         in    in_valid / in_ready    pwrcd_in_t  (duration, level, last)
//   out_*        out   out_valid / out_ready  pwrcd_out_t (code, decoded, trigger)
//   cfg_*        in    cfg_wr_en only         cfg_index, cfg_wdata
//
// one pulse per cycle unless the input side stalls: a pulse word is held in the
// input register, the window compares and the capture state update run while it
// is there, and a pulse marked last loads the result register. out_valid rises
// when the last pulse leaves the input register. the input side stalls only when a
// last pulse waits in the input register behind a result that has not been
// taken. reset (rst, synchronous) clears the capture state and loads the
// register defaults.
module pulse_width_remote_code_decoder #(
  parameter int CAPTURE_DEPTH = pwrcd_pkg::CAPTURE_DEPTH_DEF,
  parameter int CODE_BITS     = pwrcd_pkg::CODE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pwrcd_pkg::pwrcd_in_t         in_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pwrcd_pkg::pwrcd_out_t        out_word,
  input  logic                         cfg_wr_en,
  input  logic [pwrcd_pkg::IDX_W-1:0]  cfg_index,
  input  logic [pwrcd_pkg::CODE_W-1:0] cfg_wdata
);

  localparam int CntW  = $clog2(CAPTURE_DEPTH + 1);
  localparam int BitsW = $clog2(CODE_BITS + 1);
  localparam int PadW  = (CODE_BITS > pwrcd_pkg::CODE_W) ? CODE_BITS : pwrcd_pkg::CODE_W;

  // configuration registers
  logic                         rx_enable;
  logic [pwrcd_pkg::CODE_W-1:0] expected_code;
  pwrcd_pkg::pwrcd_bounds_t     bounds;

  // input register
  logic                 s1_valid;
  pwrcd_pkg::pwrcd_in_t s1_word;
  logic                 advance;

  // capture state
  logic [1:0]                  phase, phase_next;
  logic [pwrcd_pkg::DUR_W-1:0] prev_duration, prev_duration_next;
  logic                        prev_level, prev_level_next;
  logic                        prev_valid, prev_valid_next;
  logic                        half_bit, half_bit_next;
  logic [BitsW-1:0]            bits_done, bits_done_next;
  logic [CODE_BITS-1:0]        shift_value, shift_value_next;
  logic [CntW-1:0]             pulse_count, pulse_count_next;

  // window hits and result
  pwrcd_pkg::pwrcd_class_t      cur_cls, prev_cls;
  logic                         counting;
  logic                         pair_zero, pair_one;
  logic [PadW-1:0]              padded;
  logic                         ok;
  logic [pwrcd_pkg::CODE_W-1:0] res_code;
  pwrcd_pkg::pwrcd_out_t        result;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable        <= 1'b1;
      expected_code    <= '0;
      bounds.short_min <= pwrcd_pkg::SHORT_MIN_RST;
      bounds.short_max <= pwrcd_pkg::SHORT_MAX_RST;
      bounds.long_min  <= pwrcd_pkg::LONG_MIN_RST;
      bounds.long_max  <= pwrcd_pkg::LONG_MAX_RST;
      bounds.sync_min  <= pwrcd_pkg::SYNC_MIN_RST;
      bounds.sync_max  <= pwrcd_pkg::SYNC_MAX_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pwrcd_pkg::REG_RX_ENABLE:     rx_enable        <= cfg_wdata[0];
        pwrcd_pkg::REG_EXPECTED_CODE: expected_code    <= cfg_wdata;
        pwrcd_pkg::REG_SHORT_MIN:     bounds.short_min <= cfg_wdata[pwrcd_pkg::DUR_W-1:0];
        pwrcd_pkg::REG_SHORT_MAX:     bounds.short_max <= cfg_wdata[pwrcd_pkg::DUR_W-1:0];
        pwrcd_pkg::REG_LONG_MIN:      bounds.long_min  <= cfg_wdata[pwrcd_pkg::DUR_W-1:0];
        pwrcd_pkg::REG_LONG_MAX:      bounds.long_max  <= cfg_wdata[pwrcd_pkg::DUR_W-1:0];
        pwrcd_pkg::REG_SYNC_MIN:      bounds.sync_min  <= cfg_wdata[pwrcd_pkg::DUR_W-1:0];
        pwrcd_pkg::REG_SYNC_MAX:      bounds.sync_max  <= cfg_wdata[pwrcd_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: a pulse without last never waits on the output side
  assign advance  = s1_valid && (!s1_word.last || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (in_valid && in_ready) || (s1_valid && !advance);
    end
    if (in_valid && in_ready) begin
      s1_word <= in_word;
    end
  end

  // window compares on the current and the held pulse
  pwrcd_window u_cur_window (
    .duration (s1_word.duration),
    .bounds   (bounds),
    .cls      (cur_cls)
  );

  pwrcd_window u_prev_window (
    .duration (prev_duration),
    .bounds   (bounds),
    .cls      (prev_cls)
  );

  // pair decode
  assign counting  = pulse_count < CntW'(CAPTURE_DEPTH);
  assign pair_zero = prev_cls.is_short && cur_cls.is_long;
  assign pair_one  = prev_cls.is_long && cur_cls.is_short;

  // capture state update for the pulse in the input register
  always_comb begin
    phase_next         = phase;
    prev_duration_next = prev_duration;
    prev_level_next    = prev_level;
    prev_valid_next    = prev_valid;
    half_bit_next      = half_bit;
    bits_done_next     = bits_done;
    shift_value_next   = shift_value;
    pulse_count_next   = pulse_count;
    if (counting) begin
      pulse_count_next = pulse_count + 1'b1;
      unique case (phase)
        pwrcd_pkg::PH_HUNT: begin
          if (prev_valid && prev_level && prev_cls.is_short &&
              !s1_word.level && cur_cls.is_sync) begin
            phase_next       = pwrcd_pkg::PH_DATA;
            half_bit_next    = 1'b0;
            bits_done_next   = '0;
            shift_value_next = '0;
            prev_valid_next  = 1'b0;
          end else begin
            prev_duration_next = s1_word.duration;
            prev_level_next    = s1_word.level;
            prev_valid_next    = 1'b1;
          end
        end
        pwrcd_pkg::PH_DATA: begin
          if (!half_bit) begin
            prev_duration_next = s1_word.duration;
            prev_level_next    = s1_word.level;
            half_bit_next      = 1'b1;
          end else begin
            half_bit_next = 1'b0;
            if (pair_zero || pair_one) begin
              shift_value_next = CODE_BITS'({shift_value, pair_one});
              bits_done_next   = bits_done + 1'b1;
              if (bits_done_next == BitsW'(CODE_BITS)) begin
                phase_next = pwrcd_pkg::PH_DONE;
              end
            end else begin
              phase_next = pwrcd_pkg::PH_FAIL;
            end
          end
        end
        pwrcd_pkg::PH_DONE: ;
        pwrcd_pkg::PH_FAIL: ;
      endcase
    end
  end

  // result word for a pulse marked last
  assign padded          = PadW'(shift_value_next);
  assign ok              = (phase_next == pwrcd_pkg::PH_DONE) && (shift_value_next != '0);
  assign res_code        = ok ? padded[pwrcd_pkg::CODE_W-1:0] : '0;
  assign result.code     = res_code;
  assign result.decoded  = ok;
  assign result.trigger  = rx_enable && (res_code == expected_code);

  // capture state registers, cleared at the end of each capture
  always_ff @(posedge clk) begin
    if (rst || (advance && s1_word.last)) begin
      phase         <= pwrcd_pkg::PH_HUNT;
      prev_duration <= '0;
      prev_level    <= 1'b0;
      prev_valid    <= 1'b0;
      half_bit      <= 1'b0;
      bits_done     <= '0;
      shift_value   <= '0;
      pulse_count   <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      prev_duration <= prev_duration_next;
      prev_level    <= prev_level_next;
      prev_valid    <= prev_valid_next;
      half_bit      <= half_bit_next;
      bits_done     <= bits_done_next;
      shift_value   <= shift_value_next;
      pulse_count   <= pulse_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_word.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && s1_word.last) begin
      out_word <= result;
    end
  end

endmodule

// ===== src/pwrcd_checker.sv =====
// port-level checks for the pulse width remote code decoder, bound to the top
`include "pulse_width_remote_code_decoder_assert.svh"

module pwrcd_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input pwrcd_pkg::pwrcd_out_t out_word
);

  // a stalled result word holds
  `PWRCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "result word changed while stalled")

  // a decoded word never carries a zero code
  `PWRCD_ASSERT_IMPLY(a_decoded_nonzero, out_valid && out_word.decoded, out_word.code != '0, "decoded word with zero code")

  // a failed capture reports code zero
  `PWRCD_ASSERT_IMPLY(a_fail_zero, out_valid && !out_word.decoded, out_word.code == '0, "failed capture with nonzero code")

  // the input side is open whenever the result side can move
  `PWRCD_ASSERT_IMPLY(a_in_open, out_ready || !out_valid, in_ready, "input stalled while output free")

  // nothing is shown right after reset
  `PWRCD_ASSERT_IMPLY(a_reset_empty, $past(rst), !out_valid, "result word shown after reset")

endmodule

bind pulse_width_remote_code_decoder pwrcd_checker u_pwrcd_checker (.*);

// ===== bench/tb_top.sv =====
// testbench for the pulse width remote code decoder: directed captures, then random ones
`timescale 1ns / 100ps

module tb_top;

  localparam int QUIET_LIMIT = 5000;
  localparam int PAD_PULSES  = 140;
  localparam int LATE_FILL   = 100;

  // shapes of one capture
  typedef enum int {
    CAP_LONE, CAP_GOOD, CAP_BAD, CAP_NOSYNC, CAP_EARLY, CAP_LATE, CAP_PAD, CAP_NOISE
  } cap_kind_t;

  typedef struct {
    cap_kind_t                    kind;
    logic [pwrcd_pkg::CODE_W-1:0] val;
    bit                           edges;
    bit                           noisy;
    bit                           typed;
    pwrcd_pkg::pwrcd_out_t        want;
  } probe_row_t;

  typedef struct {
    bit                           en;
    logic [pwrcd_pkg::CODE_W-1:0] want;
    logic [pwrcd_pkg::DUR_W-1:0]  s_lo, s_hi, l_lo, l_hi, y_lo, y_hi;
  } knob_set_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  pwrcd_pkg::pwrcd_in_t         in_word;
  logic                         out_valid;
  logic                         out_ready;
  pwrcd_pkg::pwrcd_out_t        out_word;
  logic                         cfg_wr_en;
  logic [pwrcd_pkg::IDX_W-1:0]  cfg_index;
  logic [pwrcd_pkg::CODE_W-1:0] cfg_wdata;

  // register mirror
  bit                           m_en;
  logic [pwrcd_pkg::CODE_W-1:0] m_want;
  logic [pwrcd_pkg::DUR_W-1:0]  m_s_lo, m_s_hi, m_l_lo, m_l_hi, m_y_lo, m_y_hi;

  // capture state of the predictor
  logic [1:0]                   stage;
  logic [pwrcd_pkg::DUR_W-1:0]  held_dur;
  logic                         held_lvl;
  logic                         held_ok;
  logic                         odd_half;
  logic [4:0]                   pair_cnt;
  logic [pwrcd_pkg::CODE_W-1:0] code_acc;
  logic [7:0]                   pulses_seen;

  pwrcd_pkg::pwrcd_out_t        code_fifo [$];
  pwrcd_pkg::pwrcd_in_t         burst [$];
  pwrcd_pkg::pwrcd_out_t        oldest;

  bit                steady;
  bit                edge_pick;
  int                hold_left;
  int                quiet;
  int                items_sent;
  int                captures;
  int                results_seen;
  int                decodes;
  int                triggers;
  int                mismatches;

  // directed captures, run under the reset register values
  probe_row_t probes [0:14] = '{
    '{CAP_LONE,   24'h000000, 1'b0, 1'b0, 1'b1, '{24'h000000, 1'b0, 1'b1}},
    '{CAP_LONE,   24'h00FFFF, 1'b0, 1'b0, 1'b1, '{24'h000000, 1'b0, 1'b1}},
    '{CAP_GOOD,   24'hFFFFFF, 1'b1, 1'b0, 1'b1, '{24'hFFFFFF, 1'b1, 1'b0}},
    '{CAP_GOOD,   24'h000001, 1'b1, 1'b0, 1'b1, '{24'h000001, 1'b1, 1'b0}},
    '{CAP_GOOD,   24'h800000, 1'b0, 1'b0, 1'b1, '{24'h800000, 1'b1, 1'b0}},
    '{CAP_GOOD,   24'h000000, 1'b0, 1'b0, 1'b1, '{24'h000000, 1'b0, 1'b1}},
    '{CAP_BAD,    24'hA5A5A5, 1'b0, 1'b0, 1'b1, '{24'h000000, 1'b0, 1'b1}},
    '{CAP_NOSYNC, 24'h000000, 1'b0, 1'b0, 1'b1, '{24'h000000, 1'b0, 1'b1}},
    '{CAP_EARLY,  24'h3C3C3C, 1'b0, 1'b0, 1'b1, '{24'h000000, 1'b0, 1'b1}},
    '{CAP_LATE,   24'h5A5A5A, 1'b0, 1'b0, 1'b1, '{24'h000000, 1'b0, 1'b1}},
    '{CAP_PAD,    24'h123456, 1'b0, 1'b0, 1'b1, '{24'h123456, 1'b1, 1'b0}},
    '{CAP_GOOD,   24'h6789AB, 1'b0, 1'b1, 1'b0, '{24'h000000, 1'b0, 1'b0}},
    '{CAP_NOISE,  24'h000000, 1'b0, 1'b0, 1'b0, '{24'h000000, 1'b0, 1'b0}},
    '{CAP_NOISE,  24'h000000, 1'b0, 1'b0, 1'b0, '{24'h000000, 1'b0, 1'b0}},
    '{CAP_GOOD,   24'hC0FFEE, 1'b1, 1'b1, 1'b0, '{24'h000000, 1'b0, 1'b0}}
  };

  knob_set_t knobs [0:6];
  int        shares [0:6] = '{180, 180, 180, 180, 60, 180, 180};

  pulse_width_remote_code_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short idle stretches, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit within_win(input logic [pwrcd_pkg::DUR_W-1:0] d, lo, hi);
    return (d >= lo) && (d <= hi);
  endfunction

  // predictor: capture state cleared between captures
  task automatic restart_capture();
    stage       = pwrcd_pkg::PH_HUNT;
    held_dur    = '0;
    held_lvl    = 1'b0;
    held_ok     = 1'b0;
    odd_half    = 1'b0;
    pair_cnt    = '0;
    code_acc    = '0;
    pulses_seen = '0;
  endtask

  // predictor: sync hunt and pair decode for one pulse
  task automatic take_half(input logic [pwrcd_pkg::DUR_W-1:0] d, input logic lv);
    logic b;
    b = 1'b0;
    case (stage)
      pwrcd_pkg::PH_HUNT: begin
        if (held_ok && held_lvl && within_win(held_dur, m_s_lo, m_s_hi) &&
            !lv && within_win(d, m_y_lo, m_y_hi)) begin
          stage    = pwrcd_pkg::PH_DATA;
          odd_half = 1'b0;
          pair_cnt = '0;
          code_acc = '0;
          held_ok  = 1'b0;
        end else begin
          held_dur = d;
          held_lvl = lv;
          held_ok  = 1'b1;
        end
      end
      pwrcd_pkg::PH_DATA: begin
        if (!odd_half) begin
          held_dur = d;
          held_lvl = lv;
          odd_half = 1'b1;
        end else begin
          odd_half = 1'b0;
          if (within_win(held_dur, m_s_lo, m_s_hi) && within_win(d, m_l_lo, m_l_hi)) begin
            b = 1'b0;
          end else if (within_win(held_dur, m_l_lo, m_l_hi) &&
                       within_win(d, m_s_lo, m_s_hi)) begin
            b = 1'b1;
          end else begin
            stage = pwrcd_pkg::PH_FAIL;
          end
          if (stage == pwrcd_pkg::PH_DATA) begin
            code_acc = {code_acc[pwrcd_pkg::CODE_W-2:0], b};
            pair_cnt = pair_cnt + 5'd1;
            if (pair_cnt >= pwrcd_pkg::CODE_BITS_DEF) stage = pwrcd_pkg::PH_DONE;
          end
        end
      end
      default: ;
    endcase
  endtask

  // predictor: one accepted word, result on the last pulse of a capture
  task automatic track_pulse(input pwrcd_pkg::pwrcd_in_t w, output bit has,
                             output pwrcd_pkg::pwrcd_out_t res);
    bit ok;
    if (pulses_seen < pwrcd_pkg::CAPTURE_DEPTH_DEF) begin
      pulses_seen = pulses_seen + 8'd1;
      take_half(w.duration, w.level);
    end
    has = w.last;
    res = '0;
    if (w.last) begin
      ok          = (stage == pwrcd_pkg::PH_DONE) && (code_acc != '0);
      res.code    = ok ? code_acc : '0;
      res.decoded = ok;
      res.trigger = m_en && (res.code == m_want);
      restart_capture();
    end
  endtask

  // capture builders
  function automatic logic [pwrcd_pkg::DUR_W-1:0] rand_dur();
    return pwrcd_pkg::DUR_W'($urandom_range(0, 32767));
  endfunction

  function automatic logic [pwrcd_pkg::DUR_W-1:0] pick(
    input logic [pwrcd_pkg::DUR_W-1:0] lo, hi);
    if (lo > hi) return rand_dur();
    if (edge_pick) return ($urandom_range(0, 1) != 0) ? hi : lo;
    return pwrcd_pkg::DUR_W'($urandom_range(hi, lo));
  endfunction

  task automatic push_pulse(input logic [pwrcd_pkg::DUR_W-1:0] d, input logic lv);
    pwrcd_pkg::pwrcd_in_t w;
    w.duration = d;
    w.level    = lv;
    w.last     = 1'b0;
    burst.push_back(w);
  endtask

  task automatic add_bit(input logic b);
    logic l1, l2;
    l1 = 1'b1;
    l2 = 1'b0;
    // data levels are not checked, so scramble them now and then
    if ($urandom_range(0, 7) == 0) begin
      l1 = 1'($urandom_range(0, 1));
      l2 = 1'($urandom_range(0, 1));
    end
    if (b) begin
      push_pulse(pick(m_l_lo, m_l_hi), l1);
      push_pulse(pick(m_s_lo, m_s_hi), l2);
    end else begin
      push_pulse(pick(m_s_lo, m_s_hi), l1);
      push_pulse(pick(m_l_lo, m_l_hi), l2);
    end
  endtask

  task automatic add_bad_pair();
    case ($urandom_range(0, 2))
      0: begin
        push_pulse(pick(m_s_lo, m_s_hi), 1'b1);
        push_pulse(pick(m_s_lo, m_s_hi), 1'b0);
      end
      1: begin
        push_pulse(pick(m_l_lo, m_l_hi), 1'b1);
        push_pulse(pick(m_l_lo, m_l_hi), 1'b0);
      end
      default: begin
        push_pulse(pick(m_s_lo, m_s_hi), 1'b1);
        push_pulse(pick(m_y_lo, m_y_hi), 1'b0);
      end
    endcase
  endtask

  task automatic build_capture(input cap_kind_t kind,
                               input logic [pwrcd_pkg::CODE_W-1:0] val,
                               input bit noisy);
    int n;
    int cut;
    int bad_at;
    burst.delete();
    captures++;
    case (kind)
      CAP_LONE: push_pulse(val[pwrcd_pkg::DUR_W-1:0], val[pwrcd_pkg::DUR_W]);
      // high pulses only, so no sync can form
      CAP_NOSYNC: begin
        n = $urandom_range(1, 10);
        repeat (n) push_pulse(rand_dur(), 1'b1);
      end
      CAP_NOISE: begin
        n = $urandom_range(1, 8);
        repeat (n) push_pulse(rand_dur(), 1'($urandom_range(0, 1)));
      end
      default: begin
        if (kind == CAP_LATE) begin
          repeat (LATE_FILL) push_pulse(rand_dur(), 1'b1);
        end else if (noisy) begin
          n = $urandom_range(0, 2);
          repeat (n) push_pulse(rand_dur(), 1'($urandom_range(0, 1)));
        end
        push_pulse(pick(m_s_lo, m_s_hi), 1'b1);
        push_pulse(pick(m_y_lo, m_y_hi), 1'b0);
        bad_at = (kind == CAP_BAD) ? $urandom_range(0, pwrcd_pkg::CODE_BITS_DEF - 1) : -1;
        for (int i = pwrcd_pkg::CODE_BITS_DEF - 1; i >= 0; i--) begin
          if (i == bad_at) add_bad_pair();
          else add_bit(val[i]);
        end
        // cut the capture short somewhere before the final data pulse
        if (kind == CAP_EARLY) begin
          cut = $urandom_range(2, burst.size() - 1);
          while (burst.size() > cut) void'(burst.pop_back());
        end
        if (kind == CAP_PAD) begin
          while (burst.size() < PAD_PULSES) push_pulse(rand_dur(), 1'($urandom_range(0, 1)));
        end else if (noisy) begin
          n = $urandom_range(0, 3);
          repeat (n) push_pulse(rand_dur(), 1'($urandom_range(0, 1)));
        end
      end
    endcase
    burst[burst.size() - 1].last = 1'b1;
  endtask

  // sender: one word, held until taken
  task automatic send_pulse(input pwrcd_pkg::pwrcd_in_t w, input bit use_typed,
                            input pwrcd_pkg::pwrcd_out_t want);
    int                    g;
    bit                    has;
    pwrcd_pkg::pwrcd_out_t got;
    g = steady ? 0 : pause_len();
    if (g != 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_word  = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    track_pulse(w, has, got);
    if (has) code_fifo.push_back(use_typed ? want : got);
    @(negedge clk);
  endtask

  task automatic send_burst(input bit typed, input pwrcd_pkg::pwrcd_out_t want);
    foreach (burst[i]) send_pulse(burst[i], typed && (i == burst.size() - 1), want);
  endtask

  // sender holds off until every pending result is out
  task automatic drain();
    in_valid = 1'b0;
    while (code_fifo.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // drain, then let the pipeline empty before touching registers
  task automatic settle();
    drain();
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pwrcd_pkg::IDX_W-1:0] idx,
                           input logic [pwrcd_pkg::CODE_W-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      pwrcd_pkg::REG_RX_ENABLE:     m_en   = data[0];
      pwrcd_pkg::REG_EXPECTED_CODE: m_want = data;
      pwrcd_pkg::REG_SHORT_MIN:     m_s_lo = data[pwrcd_pkg::DUR_W-1:0];
      pwrcd_pkg::REG_SHORT_MAX:     m_s_hi = data[pwrcd_pkg::DUR_W-1:0];
      pwrcd_pkg::REG_LONG_MIN:      m_l_lo = data[pwrcd_pkg::DUR_W-1:0];
      pwrcd_pkg::REG_LONG_MAX:      m_l_hi = data[pwrcd_pkg::DUR_W-1:0];
      pwrcd_pkg::REG_SYNC_MIN:      m_y_lo = data[pwrcd_pkg::DUR_W-1:0];
      pwrcd_pkg::REG_SYNC_MAX:      m_y_hi = data[pwrcd_pkg::DUR_W-1:0];
      default: ;
    endcase
  endtask

  // upper bits carry junk, only the register width counts
  task automatic apply_knobs(input knob_set_t k);
    logic [pwrcd_pkg::CODE_W-1:0] junk;
    junk = pwrcd_pkg::CODE_W'($urandom);
    write_reg(pwrcd_pkg::REG_RX_ENABLE,     {junk[pwrcd_pkg::CODE_W-1:1], k.en});
    write_reg(pwrcd_pkg::REG_EXPECTED_CODE, k.want);
    write_reg(pwrcd_pkg::REG_SHORT_MIN,
              {junk[pwrcd_pkg::CODE_W-1:pwrcd_pkg::DUR_W], k.s_lo});
    write_reg(pwrcd_pkg::REG_SHORT_MAX,
              {junk[pwrcd_pkg::CODE_W-1:pwrcd_pkg::DUR_W], k.s_hi});
    write_reg(pwrcd_pkg::REG_LONG_MIN,
              {junk[pwrcd_pkg::CODE_W-1:pwrcd_pkg::DUR_W], k.l_lo});
    write_reg(pwrcd_pkg::REG_LONG_MAX,
              {junk[pwrcd_pkg::CODE_W-1:pwrcd_pkg::DUR_W], k.l_hi});
    write_reg(pwrcd_pkg::REG_SYNC_MIN,
              {junk[pwrcd_pkg::CODE_W-1:pwrcd_pkg::DUR_W], k.y_lo});
    write_reg(pwrcd_pkg::REG_SYNC_MAX,
              {junk[pwrcd_pkg::CODE_W-1:pwrcd_pkg::DUR_W], k.y_hi});
  endtask

  // receiver stalls
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!steady) hold_left <= pause_len();
    end
  end

  // result check against the oldest pending code
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (code_fifo.size() == 0) begin
        $error("result with nothing pending: code %h decoded %b trigger %b",
               out_word.code, out_word.decoded, out_word.trigger);
        mismatches++;
      end else begin
        oldest = code_fifo.pop_front();
        results_seen++;
        if (out_word.decoded) decodes++;
        if (out_word.trigger) triggers++;
        if (out_word.code !== oldest.code) begin
          $error("code: expected %h, got %h", oldest.code, out_word.code);
          mismatches++;
        end
        if (out_word.decoded !== oldest.decoded) begin
          $error("decoded: expected %b, got %b", oldest.decoded, out_word.decoded);
          mismatches++;
        end
        if (out_word.trigger !== oldest.trigger) begin
          $error("trigger: expected %b, got %b", oldest.trigger, out_word.trigger);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // stimulus
  initial begin : stim
    int                           lo;
    int                           r;
    int                           phase_end;
    logic [pwrcd_pkg::CODE_W-1:0] val;
    cap_kind_t                    kind;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_left = 0;
    quiet     = 0;
    steady    = 1'b0;
    edge_pick = 1'b0;
    m_en      = 1'b1;
    m_want    = '0;
    m_s_lo    = pwrcd_pkg::SHORT_MIN_RST;
    m_s_hi    = pwrcd_pkg::SHORT_MAX_RST;
    m_l_lo    = pwrcd_pkg::LONG_MIN_RST;
    m_l_hi    = pwrcd_pkg::LONG_MAX_RST;
    m_y_lo    = pwrcd_pkg::SYNC_MIN_RST;
    m_y_hi    = pwrcd_pkg::SYNC_MAX_RST;
    restart_capture();

    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (probes[i]) begin
      edge_pick = probes[i].edges;
      build_capture(probes[i].kind, probes[i].val, probes[i].noisy);
      send_burst(probes[i].typed, probes[i].want);
    end
    edge_pick = 1'b0;

    // register settings for the random part
    knobs[0] = '{1'b1, pwrcd_pkg::CODE_W'($urandom),
                 pwrcd_pkg::SHORT_MIN_RST, pwrcd_pkg::SHORT_MAX_RST,
                 pwrcd_pkg::LONG_MIN_RST, pwrcd_pkg::LONG_MAX_RST,
                 pwrcd_pkg::SYNC_MIN_RST, pwrcd_pkg::SYNC_MAX_RST};
    knobs[1] = '{1'b0, pwrcd_pkg::CODE_W'($urandom),
                 pwrcd_pkg::SHORT_MIN_RST, pwrcd_pkg::SHORT_MAX_RST,
                 pwrcd_pkg::LONG_MIN_RST, pwrcd_pkg::LONG_MAX_RST,
                 pwrcd_pkg::SYNC_MIN_RST, pwrcd_pkg::SYNC_MAX_RST};
    knobs[2] = '{1'b1, 24'hFFFFFF, 15'd0, 15'd2, 15'd3, 15'd6, 15'd7, 15'd32767};
    knobs[3] = '{1'b1, 24'h000000, 15'd20000, 15'd20500, 15'd30000, 15'd32767,
                 15'd32700, 15'd32767};
    // long window crossed: every data pair fails
    knobs[4] = '{1'b1, pwrcd_pkg::CODE_W'($urandom),
                 pwrcd_pkg::SHORT_MIN_RST, pwrcd_pkg::SHORT_MAX_RST,
                 pwrcd_pkg::LONG_MAX_RST, pwrcd_pkg::LONG_MIN_RST,
                 pwrcd_pkg::SYNC_MIN_RST, pwrcd_pkg::SYNC_MAX_RST};
    knobs[5] = '{1'b1, pwrcd_pkg::CODE_W'($urandom), 15'd100, 15'd100, 15'd300, 15'd300,
                 15'd3100, 15'd3100};
    knobs[6].en   = 1'($urandom_range(0, 1));
    knobs[6].want = pwrcd_pkg::CODE_W'($urandom);
    lo = $urandom_range(0, 1000);
    knobs[6].s_lo = pwrcd_pkg::DUR_W'(lo);
    lo += $urandom_range(0, 500);
    knobs[6].s_hi = pwrcd_pkg::DUR_W'(lo);
    lo += $urandom_range(1, 500);
    knobs[6].l_lo = pwrcd_pkg::DUR_W'(lo);
    lo += $urandom_range(0, 2000);
    knobs[6].l_hi = pwrcd_pkg::DUR_W'(lo);
    lo += $urandom_range(1, 3000);
    knobs[6].y_lo = pwrcd_pkg::DUR_W'(lo);
    lo += $urandom_range(0, 10000);
    knobs[6].y_hi = pwrcd_pkg::DUR_W'(lo);

    // random captures, one register setting per stretch
    phase_end = items_sent;
    foreach (knobs[p]) begin
      settle();
      apply_knobs(knobs[p]);
      steady = (p == 0);
      phase_end += shares[p];
      while (items_sent < phase_end) begin
        r   = $urandom_range(0, 99);
        val = (r < 30) ? m_want : (r < 35) ? '0 : (r < 40) ? '1 :
              pwrcd_pkg::CODE_W'($urandom);
        r   = $urandom_range(0, 99);
        if (r < 45)      kind = CAP_GOOD;
        else if (r < 55) kind = CAP_BAD;
        else if (r < 63) kind = CAP_EARLY;
        else if (r < 68) kind = CAP_NOSYNC;
        else if (r < 88) kind = CAP_NOISE;
        else if (r < 93) kind = CAP_LONE;
        else if (r < 96) kind = CAP_LATE;
        else             kind = CAP_PAD;
        edge_pick = ($urandom_range(0, 4) == 0);
        build_capture(kind, val, 1'($urandom_range(0, 1)));
        send_burst(1'b0, '0);
        if ($urandom_range(0, 11) == 0) drain();
      end
    end

    // wind down
    steady = 1'b0;
    drain();
    repeat (6) @(posedge clk);
    $display("covered %0d pulses in %0d captures over %0d register settings",
             items_sent, captures, $size(knobs) + 1);
    $display("%0d results checked, %0d decoded, %0d triggered, %0d mismatches",
             results_seen, decodes, triggers, mismatches);
    if (mismatches == 0 && code_fifo.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
